// File: hdl/ilid_pkg.sv
// Package for the indexed list insert/delete core.
// Holds the fixed sizes, request kinds, status codes and beat/control structs.
// No dependencies.
package ilid_pkg;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 7;
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = LEN_W;

  localparam logic [KIND_W-1:0] KIND_GET      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_AT   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [POS_W-1:0]   position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STAT_W-1:0]         status;
    logic [LEN_W-1:0]          length;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               sample;  // capture the read tap this cycle
    logic               get;     // read tap selects the cell at 'at'
    logic               ins;     // open a slot at 'at', shift upper cells up
    logic               del;     // close slot 'at', shift upper cells down
    logic [IDX_W-1:0]   at;
    logic [VALUE_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// File: hdl/ilid_cell.sv
// One storage cell of the element chain.
// Depends on ilid_pkg for the control struct and widths.
module ilid_cell
  import ilid_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   idx,
  input  cell_ctl_t          ctl,
  input  logic [VALUE_W-1:0] left,
  input  logic [VALUE_W-1:0] right,
  output logic [VALUE_W-1:0] elem,
  output logic [VALUE_W-1:0] rd
);

  logic hit;
  logic above;

  assign hit   = (idx == ctl.at);
  assign above = (idx > ctl.at);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (hit) begin
        elem <= ctl.wdata;
      end else if (above) begin
        elem <= left;
      end
    end else if (ctl.del) begin
      if (hit || above) begin
        elem <= right;
      end
    end
  end

  // Masked read tap: only the addressed cell contributes, the rest give zero.
  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      rd <= (ctl.get && hit) ? elem : '0;
    end
  end

endmodule

// File: hdl/indexed_list_insert_delete_core.sv
// Top level of the indexed list insert/delete core: sequencer, count and cell chain.
// Depends on ilid_pkg and ilid_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  req     | in        | req_valid/req_stall  | req_t  kind, position, value
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_t  read_value, status, length
//
// A request passes through accept, execute (all cells shift or write in
// parallel, count updates) and collect (OR of the masked cell read taps). The
// sequencer takes no new request until the last one has left collect.
// Reset clears the count, sequencer and rsp_valid only; element cells are not cleared.
// While rsp_stall holds a result, the next request is still accepted and
// executed; it waits in collect until the output register frees.
module indexed_list_insert_delete_core
  import ilid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  req_t              req_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] stat_q;
  logic [STAT_W-1:0] stat_next;
  logic              get_ok_q;
  logic              get_bad_q;
  logic              get_ok;
  logic              get_bad;
  cell_ctl_t         ctl;

  logic [VALUE_W-1:0] elem_w [CAPACITY];
  logic [VALUE_W-1:0] rd_w   [CAPACITY];
  logic [VALUE_W-1:0] rd_or;

  logic             pos_neg;
  logic             pos_ge;
  logic             pos_gt;
  logic             full;
  logic [POS_W-1:0] cnt_ext;
  logic             rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign cnt_ext = POS_W'(count);
  assign pos_neg = req_q.position[POS_W-1];
  assign pos_ge  = !pos_neg && (req_q.position >= cnt_ext);
  assign pos_gt  = !pos_neg && (req_q.position > cnt_ext);
  assign full    = (count == CNT_W'(CAPACITY));

  // Decode the held request against the current count.
  always_comb begin
    ctl        = '0;
    ctl.sample = (state == S_EXEC);
    ctl.wdata  = req_q.value;
    stat_next  = ST_DONE;
    count_next = count;
    get_ok     = 1'b0;
    get_bad    = 1'b0;
    case (req_q.kind)
      KIND_GET: begin
        ctl.at = req_q.position[IDX_W-1:0];
        if (pos_neg || pos_ge) begin
          stat_next = ST_INVALID;
          get_bad   = 1'b1;
        end else begin
          ctl.get = 1'b1;
          get_ok  = 1'b1;
        end
      end
      KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AT: begin
        if (req_q.kind == KIND_INS_HEAD) begin
          ctl.at = '0;
        end else if (req_q.kind == KIND_INS_TAIL) begin
          ctl.at = count[IDX_W-1:0];
        end else begin
          ctl.at = pos_neg ? '0 : req_q.position[IDX_W-1:0];
        end
        if (req_q.kind == KIND_INS_AT && pos_gt) begin
          stat_next = ST_INVALID;
        end else if (full) begin
          stat_next = ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      KIND_DEL_AT: begin
        ctl.at = req_q.position[IDX_W-1:0];
        if (pos_neg || pos_ge) begin
          stat_next = ST_INVALID;
        end else begin
          ctl.del    = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: begin
        stat_next = ST_INVALID;
      end
    endcase
    // Cells move only in the execute cycle.
    if (state != S_EXEC) begin
      ctl.get    = 1'b0;
      ctl.ins    = 1'b0;
      ctl.del    = 1'b0;
      count_next = count;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left;
      logic [VALUE_W-1:0] right;
      if (g == 0) begin : g_lo
        assign left = '0;
      end else begin : g_mid_lo
        assign left = elem_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
        assign right = elem_w[g];
      end else begin : g_mid_hi
        assign right = elem_w[g+1];
      end
      ilid_cell u_cell (
        .clk   (clk),
        .idx   (IDX_W'(g)),
        .ctl   (ctl),
        .left  (left),
        .right (right),
        .elem  (elem_w[g]),
        .rd    (rd_w[g])
      );
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_w[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      stat_q    <= stat_next;
      get_ok_q  <= get_ok;
      get_bad_q <= get_bad;
    end
    if (state == S_DONE && rsp_free) begin
      rsp.status <= stat_q;
      rsp.length <= count;
      if (get_ok_q) begin
        rsp.read_value <= rd_or;
      end else if (get_bad_q) begin
        rsp.read_value <= '1;
      end else begin
        rsp.read_value <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.length == LEN_W'(CAPACITY))
    else $error("full status with store not full");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("accepted beat did not enter execute");

  a_count_when: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state) == S_EXEC)
    else $error("count changed outside execute");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside collect");

endmodule

// File: dv/ilid_checker.sv
// Checker for the indexed list insert/delete core: watches both channels,
// keeps its own copy of the word sequence and compares every result beat.
// Depends on ilid_pkg.
module ilid_checker
  import ilid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   full_refusals,
  output int   list_len
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] words [CAPACITY];
  int                        word_count;
  rsp_t                      awaited_rsp [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $realtime, checked, msg);
    mismatches++;
  endtask

  // Apply one request to the tracked sequence and return the result it owes.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int   pos;
    int   slot;
    bit   grow;
    o        = '0;
    o.status = ST_DONE;
    pos      = r.position;
    slot     = 0;
    grow     = 1'b0;
    case (r.kind)
      KIND_GET: begin
        if (pos < 0 || pos >= word_count) begin
          o.read_value = '1;
          o.status     = ST_INVALID;
        end else begin
          o.read_value = words[pos];
        end
      end
      KIND_INS_HEAD: begin
        grow = 1'b1;
      end
      KIND_INS_TAIL: begin
        grow = 1'b1;
        slot = word_count;
      end
      KIND_INS_AT: begin
        // Past the tail is ignored even on a full store; negative goes to the head.
        if (pos > word_count) begin
          o.status = ST_INVALID;
        end else begin
          grow = 1'b1;
          slot = (pos < 0) ? 0 : pos;
        end
      end
      KIND_DEL_AT: begin
        if (pos < 0 || pos >= word_count) begin
          o.status = ST_INVALID;
        end else begin
          for (int i = pos; i < word_count - 1; i++) words[i] = words[i + 1];
          word_count--;
        end
      end
      default: begin
        o.status = ST_INVALID;
      end
    endcase
    if (grow) begin
      if (word_count >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        for (int i = word_count; i > slot; i--) words[i] = words[i - 1];
        words[slot] = r.value;
        word_count++;
      end
    end
    o.length = word_count[LEN_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      word_count = 0;
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("result beat with no request outstanding (%p)", rsp));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      rsp.read_value, want.read_value));
          end
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          end
          if (rsp.length !== want.length) begin
            report_mismatch($sformatf("length %0d, expected %0d", rsp.length, want.length));
          end
          checked++;
        end
      end
      if (req_valid && !req_stall) begin
        want = apply_request(req);
        if (want.status == ST_FULL) full_refusals++;
        awaited_rsp.push_back(want);
      end
    end
    pending  <= awaited_rsp.size();
    list_len <= word_count;
  end

endmodule

// File: dv/tb_indexed_list_insert_delete_core.sv
// Testbench top for the indexed list insert/delete core: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on ilid_pkg, indexed_list_insert_delete_core and ilid_checker.
module tb_indexed_list_insert_delete_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ilid_pkg::*;

  localparam int ITEMS       = 700;
  localparam int QUIET_TAIL  = 100;
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_AFTER  = 350;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_DEL_AT + 1'b1;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

  localparam logic signed [VALUE_W-1:0] WORD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] WORD_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int sent  = 0;
  bit quiet = 1'b0;
  int mismatches;
  int pending;
  int checked;
  int full_refusals;
  int list_len;

  indexed_list_insert_delete_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ilid_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .mismatches    (mismatches),
    .pending       (pending),
    .checked       (checked),
    .full_refusals (full_refusals),
    .list_len      (list_len)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the design hangs.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic req_t make_req(input logic [KIND_W-1:0] k, input int p, input int v);
    req_t r;
    r.kind     = k;
    r.position = p;
    r.value    = v;
    return r;
  endfunction

  // Offer one request beat, with an occasional idle burst ahead of it; hold until taken.
  task automatic offer(input req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  // Result side: random stall bursts, one long hold-off, none near the end.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (quiet) begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end else if (!held && sent >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    req_t plan [$];
    req_t r;
    int   pick;
    int   len_now;
    int   full_streak;
    int   empty_streak;
    int   drain;
    bit   growing;

    // Corners: empty store, every kind, boundary positions, extreme words.
    plan.push_back(make_req(KIND_GET, 0, 0));
    plan.push_back(make_req(KIND_DEL_AT, 0, 0));
    plan.push_back(make_req(KIND_INS_AT, 1, 7));
    plan.push_back(make_req(KIND_INS_AT, 0, WORD_MAX));
    plan.push_back(make_req(KIND_INS_HEAD, 0, WORD_MIN));
    plan.push_back(make_req(KIND_INS_TAIL, 0, -1));
    plan.push_back(make_req(KIND_INS_AT, WORD_MIN, 0));
    plan.push_back(make_req(KIND_INS_AT, 2, 32'h5A5A_A5A5));
    plan.push_back(make_req(KIND_INS_AT, 5, 32'h1234_5678));
    plan.push_back(make_req(KIND_INS_AT, WORD_MAX, 3));
    plan.push_back(make_req(KIND_GET, 0, 0));
    plan.push_back(make_req(KIND_GET, 5, 0));
    plan.push_back(make_req(KIND_GET, 6, 0));
    plan.push_back(make_req(KIND_GET, WORD_MIN, 0));
    plan.push_back(make_req(KIND_GET, WORD_MAX, 0));
    plan.push_back(make_req(KIND_DEL_AT, -1, 0));
    plan.push_back(make_req(KIND_DEL_AT, 6, 0));
    plan.push_back(make_req(KIND_DEL_AT, WORD_MAX, 0));
    plan.push_back(make_req(KIND_DEL_AT, 5, 0));
    plan.push_back(make_req(KIND_DEL_AT, 0, 0));
    plan.push_back(make_req(KIND_DEL_AT, 2, 0));
    plan.push_back(make_req(KIND_UNUSED_LO, 1, -1));
    plan.push_back(make_req(KIND_UNUSED_LO + 1'b1, -1, WORD_MAX));
    plan.push_back(make_req(KIND_UNUSED_HI, WORD_MIN, WORD_MIN));
    plan.push_back(make_req(KIND_GET, 1, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i]);

    // Alternate between filling to capacity and draining to empty.
    growing      = 1'b1;
    full_streak  = 0;
    empty_streak = 0;
    for (int n = 0; n < ITEMS; n++) begin
      quiet   = (n >= ITEMS - QUIET_TAIL);
      len_now = list_len;
      if (growing && len_now >= CAPACITY) full_streak++;
      if (!growing && len_now == 0) empty_streak++;
      if (full_streak > 8) begin
        growing     = 1'b0;
        full_streak = 0;
      end
      if (empty_streak > 3) begin
        growing      = 1'b1;
        empty_streak = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        r.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      end else if (growing) begin
        r.kind = (pick < 12) ? KIND_GET : (pick < 30) ? KIND_INS_HEAD :
                 (pick < 50) ? KIND_INS_TAIL : (pick < 75) ? KIND_INS_AT : KIND_DEL_AT;
      end else begin
        r.kind = (pick < 20) ? KIND_GET : (pick < 27) ? KIND_INS_HEAD :
                 (pick < 34) ? KIND_INS_TAIL : (pick < 42) ? KIND_INS_AT : KIND_DEL_AT;
      end

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.position = $urandom_range(0, len_now);
      end else if (pick == 6) begin
        r.position = len_now + $urandom_range(0, 2);
      end else if (pick == 7) begin
        r.position = -int'($urandom_range(1, 3));
      end else begin
        r.position = $urandom;
      end

      case ($urandom_range(0, 7))
        0: r.value = '0;
        1: r.value = '1;
        2: r.value = WORD_MIN;
        3: r.value = WORD_MAX;
        default: r.value = $urandom;
      endcase

      offer(r);
    end
    req_valid <= 1'b0;

    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (pending != 0 && drain < 2000);
    repeat (20) @(posedge clk);

    $display("Run: %0d requests over fill-to-capacity and drain cycles, %0d results compared.",
             sent, checked);
    $display("Inserts refused on a full store: %0d; one output hold-off of %0d cycles.",
             full_refusals, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
